// ===== rtl/core/sbb_pkg.sv =====
// ----------------------------------------------------------------------------
// sbb_pkg
// Shared types, constants and channel arithmetic for the 3x3 separable box
// blur: item structs, register map, output queue sizing, truncated means.
// ----------------------------------------------------------------------------
package sbb_pkg;

  // frame size limits and register reset values
  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 4096;
  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 13;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // apb port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // pixel format
  localparam int CHAN_W = 8;
  localparam int NCHAN  = 3;
  localparam int PIX_W  = CHAN_W * NCHAN;

  // floor(s / 3) for s < 2048 as (s * 683) >> 11
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;

  // output queue
  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PW    = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

  typedef logic [PIX_W-1:0] pix_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_DRAIN = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_end;
  } out_item_t;

  // results handed from the vertical lanes to the merge stage
  typedef struct packed {
    logic a_vld;
    logic b_vld;
    logic frame_end;
  } push_t;

  // truncated mean of two channel values
  function automatic logic [CHAN_W-1:0] mean2(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      return s[CHAN_W:1];
    end
  endfunction

  // truncated mean of three channel values, reciprocal multiply
  function automatic logic [CHAN_W-1:0] mean3(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [CHAN_W-1:0] c);
    logic [CHAN_W+1:0]     s;
    logic [2*CHAN_W+3:0]   prod;
    begin
      s    = (CHAN_W+2)'(a) + (CHAN_W+2)'(b) + (CHAN_W+2)'(c);
      prod = (2*CHAN_W+4)'(s) * (2*CHAN_W+4)'(DIV3_MUL);
      return prod[DIV3_SHIFT +: CHAN_W];
    end
  endfunction

endpackage

// ===== rtl/core/sbb_ram.sv =====
// ----------------------------------------------------------------------------
// sbb_ram
// Generic single-write, single-read RAM with registered read data.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module sbb_ram #(
  parameter int WIDTH = sbb_pkg::PIX_W,
  parameter int DEPTH = sbb_pkg::MAX_WIDTH / 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read-first storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/sbb_hlane.sv =====
// ----------------------------------------------------------------------------
// sbb_hlane
// Horizontal pass for one color channel: mean over the row neighbors for the
// column behind the incoming pixel, and the two-value mean at the row end.
// ----------------------------------------------------------------------------
module sbb_hlane (
  input  logic [sbb_pkg::CHAN_W-1:0] prev2,
  input  logic [sbb_pkg::CHAN_W-1:0] prev1,
  input  logic [sbb_pkg::CHAN_W-1:0] cur,
  input  logic                       near_start,
  output logic [sbb_pkg::CHAN_W-1:0] h_mid,
  output logic [sbb_pkg::CHAN_W-1:0] h_end
);

  // first column has only its right neighbor
  always_comb begin
    h_end = sbb_pkg::mean2(prev1, cur);
    if (near_start) begin
      h_mid = h_end;
    end else begin
      h_mid = sbb_pkg::mean3(prev2, prev1, cur);
    end
  end

endmodule

// ===== rtl/core/sbb_vlane.sv =====
// ----------------------------------------------------------------------------
// sbb_vlane
// Vertical pass for one color channel of one result slot: three-row mean
// inside the frame, two-row mean on the first and last rows.
// ----------------------------------------------------------------------------
module sbb_vlane (
  input  logic [sbb_pkg::CHAN_W-1:0] x0,
  input  logic [sbb_pkg::CHAN_W-1:0] x1,
  input  logic [sbb_pkg::CHAN_W-1:0] x2,
  input  logic                       sel3,
  output logic [sbb_pkg::CHAN_W-1:0] y
);

  // pick the mean that matches the row position
  always_comb begin
    if (sel3) begin
      y = sbb_pkg::mean3(x0, x1, x2);
    end else begin
      y = sbb_pkg::mean2(x0, x1);
    end
  end

endmodule

// ===== rtl/core/sbb_merge.sv =====
// ----------------------------------------------------------------------------
// sbb_merge
// Merges the channel lanes of up to two result slots into result items and
// queues them for the output channel, slot a ahead of slot b.
// ----------------------------------------------------------------------------
module sbb_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sbb_pkg::push_t                push,
  input  sbb_pkg::pix_t                 res_a,
  input  sbb_pkg::pix_t                 res_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sbb_pkg::out_item_t            out_data,
  output logic [sbb_pkg::OFIFO_CW-1:0]  count
);

  localparam int PW = sbb_pkg::OFIFO_PW;
  localparam int CW = sbb_pkg::OFIFO_CW;
  localparam int CH = sbb_pkg::CHAN_W;

  sbb_pkg::out_item_t q_r [sbb_pkg::OFIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_b;
  logic [CW-1:0] cnt_r, cnt_nxt, n_push;
  logic          pop;
  sbb_pkg::out_item_t item_a, item_b;

  // assemble items from the channel lanes
  always_comb begin
    item_a.red_out   = res_a[2*CH +: CH];
    item_a.green_out = res_a[CH +: CH];
    item_a.blue_out  = res_a[0 +: CH];
    item_a.frame_end = push.frame_end;
    item_b.red_out   = res_b[2*CH +: CH];
    item_b.green_out = res_b[CH +: CH];
    item_b.blue_out  = res_b[0 +: CH];
    item_b.frame_end = 1'b0;
  end

  // pointer and fill bookkeeping
  always_comb begin
    pop        = (cnt_r != '0) && !out_stall;
    n_push     = CW'(push.a_vld) + CW'(push.b_vld);
    wr_ptr_b   = wr_ptr_r + PW'(push.a_vld);
    wr_ptr_nxt = wr_ptr_r + PW'(n_push);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    cnt_nxt    = cnt_r + n_push - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push.a_vld) begin
      q_r[wr_ptr_r] <= item_a;
    end
    if (push.b_vld) begin
      q_r[wr_ptr_b] <= item_b;
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

// ===== rtl/core/separable_box_blur_3x3.sv =====
// ----------------------------------------------------------------------------
// separable_box_blur_3x3
// Pipeline: the item that completes a window passes the stage 1 registers
//   and the output queue; the picture lags one row and one pixel behind.
// Throughput: one item per clock while in_stall is low; a row-end item gives
//   two results into a four-entry output queue and may hold the input off.
// Reset: synchronous; clears counters, window and queue, size to 640x480.
//   The line store is not cleared.
// ----------------------------------------------------------------------------
module separable_box_blur_3x3 #(
  parameter int MAX_WIDTH  = sbb_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = sbb_pkg::MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbb_pkg::PADDR_W-1:0]   paddr,
  input  logic [sbb_pkg::PDATA_W-1:0]   pwdata,
  output logic [sbb_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // pixel input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sbb_pkg::in_item_t             in_data,
  // blurred output
  output logic                          out_valid,
  input  logic                          out_stall,
  output sbb_pkg::out_item_t            out_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int WCMP   = (CW + 1 > sbb_pkg::CFG_WIDTH_W) ? CW + 1 : sbb_pkg::CFG_WIDTH_W;
  localparam int HCMP   = (RW + 1 > sbb_pkg::CFG_HEIGHT_W) ? RW + 1 : sbb_pkg::CFG_HEIGHT_W;
  localparam int RAM_D  = (MAX_WIDTH + 1) / 2;
  localparam int RAM_AW = (RAM_D > 1) ? $clog2(RAM_D) : 1;
  localparam int CH     = sbb_pkg::CHAN_W;
  localparam int NCH    = sbb_pkg::NCHAN;
  localparam int QCW    = sbb_pkg::OFIFO_CW;

  // configuration registers
  logic [sbb_pkg::CFG_WIDTH_W-1:0]  cfg_width_r;
  logic [sbb_pkg::CFG_HEIGHT_W-1:0] cfg_height_r;
  logic                             cfg_wr;

  // frame position
  logic [CW-1:0] col_r, col_nxt, drn_r, drn_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          pend_r, pend_nxt;
  sbb_pkg::pix_t win0_r, win1_r, pix;

  // stage 1
  logic          s1_a_r, s1_b_r, s1_drain_r, s1_row1_r, s1_last_r, s1_set_r, s1_bank_r;
  sbb_pkg::pix_t s1_ha_r, s1_hb_r;

  logic [WCMP-1:0] w_raw, w_eff;
  logic [HCMP-1:0] h_raw, h_eff;
  logic [CW-1:0]   wm1;
  logic [RW-1:0]   hm1;

  logic          acc, acc_pix, acc_drn;
  logic [CW-1:0] col_eff, col_a;
  logic [RW-1:0] row_eff;
  logic          a_act, b_act, near_start, last_row, drn_last, row_ge1;
  logic          set_a, bank;
  logic [RAM_AW-1:0] addr_a, addr_b;
  sbb_pkg::pix_t h_mid, h_end;

  logic [RAM_AW-1:0] set_addr [2];
  sbb_pkg::pix_t     set_wdat [2];
  logic              set_wact [2];
  sbb_pkg::pix_t     ram_q [2][2];

  sbb_pkg::pix_t vx0 [2];
  sbb_pkg::pix_t vx1 [2];
  sbb_pkg::pix_t vx2 [2];
  logic          vsel3 [2];
  sbb_pkg::pix_t vres [2];

  sbb_pkg::push_t     push;
  logic [QCW-1:0]     q_count, occ;

  // apb register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (sbb_pkg::reg_idx_t'(paddr[2]))
      sbb_pkg::REG_IMAGE_WIDTH:  prdata = sbb_pkg::PDATA_W'(cfg_width_r);
      sbb_pkg::REG_IMAGE_HEIGHT: prdata = sbb_pkg::PDATA_W'(cfg_height_r);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= sbb_pkg::CFG_WIDTH_W'(sbb_pkg::RESET_WIDTH);
      cfg_height_r <= sbb_pkg::CFG_HEIGHT_W'(sbb_pkg::RESET_HEIGHT);
    end else if (cfg_wr) begin
      unique case (sbb_pkg::reg_idx_t'(paddr[2]))
        sbb_pkg::REG_IMAGE_WIDTH:  cfg_width_r  <= pwdata[sbb_pkg::CFG_WIDTH_W-1:0];
        sbb_pkg::REG_IMAGE_HEIGHT: cfg_height_r <= pwdata[sbb_pkg::CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp frame size into the supported range
  always_comb begin
    w_raw = WCMP'(cfg_width_r);
    if (w_raw < WCMP'(2)) begin
      w_eff = WCMP'(2);
    end else if (w_raw > WCMP'(MAX_WIDTH)) begin
      w_eff = WCMP'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_raw = HCMP'(cfg_height_r);
    if (h_raw < HCMP'(2)) begin
      h_eff = HCMP'(2);
    end else if (h_raw > HCMP'(MAX_HEIGHT)) begin
      h_eff = HCMP'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
    wm1 = CW'(w_eff - WCMP'(1));
    hm1 = RW'(h_eff - HCMP'(1));
  end

  // input handshake, credit against the output queue
  assign occ      = q_count + QCW'(s1_a_r) + QCW'(s1_b_r);
  assign in_stall = !rst_n || (occ > QCW'(sbb_pkg::OFIFO_DEPTH - 2));
  assign acc      = in_valid && !in_stall;
  assign acc_pix  = acc && (in_data.mode == sbb_pkg::MODE_PIXEL);
  assign acc_drn  = acc && (in_data.mode == sbb_pkg::MODE_DRAIN) && pend_r;
  assign pix      = {in_data.red_in, in_data.green_in, in_data.blue_in};

  // position decode; a pixel after a finished frame starts a new one
  always_comb begin
    col_eff    = pend_r ? '0 : col_r;
    row_eff    = pend_r ? '0 : row_r;
    a_act      = (col_eff != '0);
    b_act      = (col_eff >= wm1);
    near_start = (col_eff == CW'(1));
    last_row   = (row_eff >= hm1);
    drn_last   = (drn_r >= wm1);
    row_ge1    = (row_eff != '0);
    col_a      = acc_pix ? (col_eff - CW'(1)) : drn_r;
    set_a      = acc_pix ? !col_eff[0] : drn_r[0];
    bank       = acc_pix ? row_eff[0] : row_r[0];
    addr_a     = RAM_AW'(col_a >> 1);
    addr_b     = RAM_AW'(col_eff >> 1);
  end

  // counter next state
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    drn_nxt  = drn_r;
    pend_nxt = pend_r;
    if (acc_pix) begin
      pend_nxt = 1'b0;
      drn_nxt  = pend_r ? '0 : drn_r;
      row_nxt  = row_eff;
      if (b_act) begin
        col_nxt = '0;
        if (last_row) begin
          pend_nxt = 1'b1;
          drn_nxt  = '0;
        end else begin
          row_nxt = row_eff + RW'(1);
        end
      end else begin
        col_nxt = col_eff + CW'(1);
      end
    end else if (acc_drn) begin
      if (drn_last) begin
        pend_nxt = 1'b0;
        drn_nxt  = '0;
        row_nxt  = '0;
        col_nxt  = '0;
      end else begin
        drn_nxt = drn_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      drn_r  <= '0;
      pend_r <= 1'b0;
      win0_r <= '0;
      win1_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      drn_r  <= drn_nxt;
      pend_r <= pend_nxt;
      if (acc_pix) begin
        win1_r <= win0_r;
        win0_r <= pix;
      end
    end
  end

  // horizontal lanes, one per channel
  for (genvar ch = 0; ch < NCH; ch++) begin : g_hlane
    sbb_hlane u_hlane (
      .prev2      (win1_r[ch*CH +: CH]),
      .prev1      (win0_r[ch*CH +: CH]),
      .cur        (pix[ch*CH +: CH]),
      .near_start (near_start),
      .h_mid      (h_mid[ch*CH +: CH]),
      .h_end      (h_end[ch*CH +: CH])
    );
  end

  // line store: column parity by row parity, adjacent columns never collide
  for (genvar p = 0; p < 2; p++) begin : g_set
    always_comb begin
      if (set_a == 1'(p)) begin
        set_addr[p] = addr_a;
        set_wdat[p] = h_mid;
        set_wact[p] = acc_pix && a_act;
      end else begin
        set_addr[p] = addr_b;
        set_wdat[p] = h_end;
        set_wact[p] = acc_pix && b_act;
      end
    end
    for (genvar k = 0; k < 2; k++) begin : g_bank
      sbb_ram #(
        .WIDTH (sbb_pkg::PIX_W),
        .DEPTH (RAM_D)
      ) u_ram (
        .clk     (clk),
        .wr_en   (set_wact[p] && (bank == 1'(k))),
        .wr_addr (set_addr[p]),
        .wr_data (set_wdat[p]),
        .rd_addr (set_addr[p]),
        .rd_data (ram_q[p][k])
      );
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_a_r <= 1'b0;
      s1_b_r <= 1'b0;
    end else begin
      s1_a_r <= (acc_pix && a_act && row_ge1) || acc_drn;
      s1_b_r <= acc_pix && b_act && row_ge1;
    end
  end

  always_ff @(posedge clk) begin
    s1_drain_r <= acc_drn;
    s1_row1_r  <= (row_eff == RW'(1));
    s1_last_r  <= acc_drn && drn_last;
    s1_set_r   <= set_a;
    s1_bank_r  <= bank;
    s1_ha_r    <= h_mid;
    s1_hb_r    <= h_end;
  end

  // vertical operands for both slots
  always_comb begin
    vx0[0]   = ram_q[s1_set_r][!s1_bank_r];
    vx2[0]   = ram_q[s1_set_r][s1_bank_r];
    vx1[0]   = s1_drain_r ? vx2[0] : s1_ha_r;
    vsel3[0] = !s1_drain_r && !s1_row1_r;
    vx0[1]   = ram_q[!s1_set_r][!s1_bank_r];
    vx2[1]   = ram_q[!s1_set_r][s1_bank_r];
    vx1[1]   = s1_hb_r;
    vsel3[1] = !s1_row1_r;
  end

  // vertical lanes, one per slot and channel
  for (genvar s = 0; s < 2; s++) begin : g_slot
    for (genvar ch = 0; ch < NCH; ch++) begin : g_vlane
      sbb_vlane u_vlane (
        .x0   (vx0[s][ch*CH +: CH]),
        .x1   (vx1[s][ch*CH +: CH]),
        .x2   (vx2[s][ch*CH +: CH]),
        .sel3 (vsel3[s]),
        .y    (vres[s][ch*CH +: CH])
      );
    end
  end

  // merge and queue results
  always_comb begin
    push.a_vld     = s1_a_r;
    push.b_vld     = s1_b_r;
    push.frame_end = s1_last_r;
  end

  sbb_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res_a     (vres[0]),
    .res_b     (vres[1]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (q_count)
  );

endmodule

// ===== rtl/core/sbb_checker.sv =====
// ----------------------------------------------------------------------------
// sbb_checker
// Port-level checks for the box blur: output hold under stall, reset state,
// result origin and input credit.
// ----------------------------------------------------------------------------
module sbb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sbb_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  // reset empties the output side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a new result comes from an earlier input transfer
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without input transfer");

  // with nothing queued there is always room for another item
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output queue");

endmodule

bind separable_box_blur_3x3 sbb_checker u_sbb_checker (.*);
